/* hdl/sspc_pkg.sv */
// Shared types, codes and default sizes for the searchable stack with parity counts.
package sspc_pkg;

    // Default sizes, handed to the top-level parameters.
    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed field widths of the stream interface.
    localparam int OP_W     = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int DIST_W   = 6;
    localparam int COUNT_W  = 7;
    localparam int OUT_DATA_W = 32;
    localparam int OUT_PAD_W  = OUT_DATA_W - DIST_W - 3 * COUNT_W;

    // Request codes. Code 3 carries no meaning and is answered as a no-op.
    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_SEARCH = 2'd2
    } t_op;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;       // capture the incoming word, restart the search index
        logic    push;       // write the word on top and count its parity
        logic    pop_dec;    // drop the top and start reading it
        logic    pop_fin;    // take the popped word off its parity count
        logic    srch_step;  // advance the search walk by one entry
        logic    take_dist;  // record the distance of the current match
        logic    out_load;   // load the result register
        t_status out_status; // status that goes with the result
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic empty;
        logic hit;   // compared entry equals the key
        logic last;  // compared entry is the bottom of the stack
    } t_stat;

endpackage

/* hdl/sspc_ctrl.sv */
// Controller state machine: sequences push, pop and search and hands off results.
module sspc_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [sspc_pkg::OP_W-1:0]       i_op,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  sspc_pkg::t_stat                 i_stat,
    output sspc_pkg::t_cmd                  o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PUSH  = 6'b000010,
        S_POP   = 6'b000100,
        S_POPRD = 6'b001000,
        S_SRCH  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state            r_state, n_state;
    sspc_pkg::t_status r_status, n_status;
    logic              r_m_valid, n_m_valid;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;

    always_comb begin
        n_state   = r_state;
        n_status  = r_status;
        n_m_valid = r_m_valid;
        o_cmd     = '0;
        o_cmd.out_status = r_status;

        if (r_m_valid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_status   = sspc_pkg::ST_OK;
                    case (i_op)
                        sspc_pkg::OP_PUSH:   n_state = S_PUSH;
                        sspc_pkg::OP_POP:    n_state = S_POP;
                        sspc_pkg::OP_SEARCH: n_state = S_SRCH;
                        default:             n_state = S_DONE;
                    endcase
                end
            end
            S_PUSH: begin
                if (i_stat.full) begin
                    n_status = sspc_pkg::ST_FULL;
                end else begin
                    o_cmd.push = 1'b1;
                end
                n_state = S_DONE;
            end
            S_POP: begin
                if (i_stat.empty) begin
                    n_status = sspc_pkg::ST_EMPTY;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.pop_dec = 1'b1;
                    n_state       = S_POPRD;
                end
            end
            S_POPRD: begin
                o_cmd.pop_fin = 1'b1;
                n_state       = S_DONE;
            end
            S_SRCH: begin
                o_cmd.srch_step = 1'b1;
                if (i_stat.empty) begin
                    n_status = sspc_pkg::ST_NOT_FOUND;
                    n_state  = S_DONE;
                end else if (i_stat.hit) begin
                    o_cmd.take_dist = 1'b1;
                    n_state         = S_DONE;
                end else if (i_stat.last) begin
                    n_status = sspc_pkg::ST_NOT_FOUND;
                    n_state  = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_m_valid || m_axis_tready) begin
                    o_cmd.out_load = 1'b1;
                    n_m_valid      = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_status  <= sspc_pkg::ST_OK;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_status  <= n_status;
            r_m_valid <= n_m_valid;
        end
    end

endmodule

/* hdl/sspc_dp.sv */
// Datapath: stack memory, fill pointer, parity counters, search walk and result register.
module sspc_dp #(
    parameter int CAPACITY   = sspc_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = sspc_pkg::DATA_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic signed [sspc_pkg::VALUE_W-1:0] i_value,
    input  sspc_pkg::t_cmd                      i_cmd,
    output sspc_pkg::t_stat                     o_stat,
    output logic [sspc_pkg::STATUS_W-1:0]       o_status,
    output logic [sspc_pkg::OUT_DATA_W-1:0]     o_data
);

    localparam int PTR_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = $clog2(CAPACITY);

    logic [DATA_WIDTH-1:0] mem [CAPACITY];
    logic [DATA_WIDTH-1:0] r_rd_data;
    logic [ADDR_W-1:0]     rd_addr;

    logic [DATA_WIDTH-1:0] r_word;
    logic [PTR_W-1:0]      r_sp, n_sp;
    logic [PTR_W-1:0]      r_odd, n_odd;
    logic [PTR_W-1:0]      r_even, n_even;
    logic [PTR_W-1:0]      r_idx;
    logic [PTR_W-1:0]      r_cmp_idx;
    logic                  r_cmp_vld;
    logic [PTR_W-1:0]      r_dist;

    logic [sspc_pkg::STATUS_W-1:0] r_out_status;
    logic [sspc_pkg::DIST_W-1:0]   r_out_dist;
    logic [sspc_pkg::COUNT_W-1:0]  r_out_odd;
    logic [sspc_pkg::COUNT_W-1:0]  r_out_even;
    logic [sspc_pkg::COUNT_W-1:0]  r_out_fill;

    // Entry below the top by r_idx; r_idx is zero during a pop.
    assign rd_addr = ADDR_W'(r_sp - PTR_W'(1) - r_idx);

    assign o_stat.full  = (r_sp == PTR_W'(CAPACITY));
    assign o_stat.empty = (r_sp == '0);
    assign o_stat.hit   = r_cmp_vld && (r_rd_data == r_word);
    assign o_stat.last  = r_cmp_vld && (r_cmp_idx == PTR_W'(r_sp - PTR_W'(1)));

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            mem[ADDR_W'(r_sp)] <= r_word;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_comb begin
        n_sp   = r_sp;
        n_odd  = r_odd;
        n_even = r_even;
        if (i_cmd.push) begin
            n_sp = r_sp + PTR_W'(1);
            if (r_word[0]) begin
                n_odd = r_odd + PTR_W'(1);
            end else begin
                n_even = r_even + PTR_W'(1);
            end
        end
        if (i_cmd.pop_dec) begin
            n_sp = r_sp - PTR_W'(1);
        end
        if (i_cmd.pop_fin) begin
            if (r_rd_data[0]) begin
                if (r_odd != '0) begin
                    n_odd = r_odd - PTR_W'(1);
                end
            end else begin
                if (r_even != '0) begin
                    n_even = r_even - PTR_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp      <= '0;
            r_odd     <= '0;
            r_even    <= '0;
            r_idx     <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_sp   <= n_sp;
            r_odd  <= n_odd;
            r_even <= n_even;
            if (i_cmd.load) begin
                r_idx     <= '0;
                r_cmp_vld <= 1'b0;
            end else if (i_cmd.srch_step) begin
                // The read issued this cycle is compared in the next one.
                r_cmp_vld <= (r_idx < r_sp);
                if (r_idx < r_sp) begin
                    r_idx <= r_idx + PTR_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_word <= DATA_WIDTH'(i_value);
            r_dist <= '0;
        end
        if (i_cmd.srch_step) begin
            r_cmp_idx <= r_idx;
        end
        if (i_cmd.take_dist) begin
            r_dist <= r_cmp_idx;
        end
        if (i_cmd.out_load) begin
            r_out_status <= i_cmd.out_status;
            r_out_dist   <= sspc_pkg::DIST_W'(r_dist);
            r_out_odd    <= sspc_pkg::COUNT_W'(r_odd);
            r_out_even   <= sspc_pkg::COUNT_W'(r_even);
            r_out_fill   <= sspc_pkg::COUNT_W'(r_sp);
        end
    end

    assign o_status = r_out_status;
    assign o_data   = {{sspc_pkg::OUT_PAD_W{1'b0}}, r_out_fill, r_out_even,
                       r_out_odd, r_out_dist};

endmodule

/* hdl/searchable_stack_parity_count.sv */
// Top level of the searchable stack with parity counts.
//
//  Channel   Direction  tdata (lowest bit up)                 tuser
//  s_axis    in         value[31:0]                           operation[1:0]
//  m_axis    out        distance[5:0], odd_count[12:6],       status[1:0]
//                       even_count[19:13], fill_level[26:20],
//                       zeros[31:27]
//
// One item is worked on at a time. A push goes through S_PUSH and a pop through
// S_POP and S_POPRD before S_DONE loads the result register; a search walks at
// most n entries, where n is the fill level, reading the stack memory one
// entry per cycle through its single registered read port, top first.
// Reset clears the fill level and both parity counts; the stack memory is
// not cleared and needs no clearing pass. A stalled output holds its result,
// and the next item is accepted while that result waits to be taken.
module searchable_stack_parity_count #(
    parameter int CAPACITY   = sspc_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = sspc_pkg::DATA_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Request stream.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [sspc_pkg::VALUE_W-1:0]        s_axis_tdata,  // value[31:0]
    input  logic [sspc_pkg::OP_W-1:0]           s_axis_tuser,  // operation[1:0]
    // Result stream.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // distance[5:0], odd_count[12:6], even_count[19:13], fill_level[26:20], zeros
    output logic [sspc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic [sspc_pkg::STATUS_W-1:0]       m_axis_tuser   // status[1:0]
);

    sspc_pkg::t_cmd  cmd;
    sspc_pkg::t_stat stat;

    // The controller decides what happens to each item; the datapath holds
    // the stack, its counters and the result register.
    sspc_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .i_op          (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_stat        (stat),
        .o_cmd         (cmd)
    );

    // The incoming value is a signed word; the datapath sign-extends or
    // truncates it to the stored word width.
    sspc_dp #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_value  (signed'(s_axis_tdata)),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_status (m_axis_tuser),
        .o_data   (m_axis_tdata)
    );

endmodule

/* tb/tb_searchable_stack_parity_count.sv */
// Self-checking testbench for the searchable stack with parity counts.
module tb_searchable_stack_parity_count;

    localparam int DEPTH = sspc_pkg::CAPACITY_DEF;

    // Request code 3 has no meaning; the block answers it without touching the stack.
    localparam logic [sspc_pkg::OP_W-1:0] OP_NOP = 2'd3;

    // Bit positions of the result fields inside m_axis_tdata.
    localparam int ODD_LSB  = sspc_pkg::DIST_W;
    localparam int EVEN_LSB = sspc_pkg::DIST_W + sspc_pkg::COUNT_W;
    localparam int FILL_LSB = sspc_pkg::DIST_W + 2 * sspc_pkg::COUNT_W;
    localparam int PAD_LSB  = sspc_pkg::DIST_W + 3 * sspc_pkg::COUNT_W;

    // Non-ignored items per random phase; three phases bring the run to about 950 items.
    localparam int PHASE_ITEMS     = 290;
    localparam int HOLD_OFF_CYCLES = 300;
    // A full-depth search is the slowest item, so the tail grows with DEPTH.
    localparam int TAIL_CYCLES     = DEPTH + 16;
    localparam int STALL_LIMIT     = 4000;

    typedef struct {
        sspc_pkg::t_status               status;
        logic [sspc_pkg::DIST_W-1:0]     distance;
        logic [sspc_pkg::COUNT_W-1:0]    odd_count;
        logic [sspc_pkg::COUNT_W-1:0]    even_count;
        logic [sspc_pkg::COUNT_W-1:0]    fill_level;
    } t_result;

    // One request as offered on the input stream. When has_fixed is set, the
    // typed-in result is the expectation instead of the predicted one.
    typedef struct {
        logic [sspc_pkg::OP_W-1:0]    op;
        logic [sspc_pkg::VALUE_W-1:0] value;
        bit                           has_fixed;
        t_result                      fixed;
    } t_request;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              s_axis_tvalid;
    logic                              s_axis_tready;
    logic [sspc_pkg::VALUE_W-1:0]      s_axis_tdata;   // value[31:0]
    logic [sspc_pkg::OP_W-1:0]         s_axis_tuser;   // operation[1:0]
    logic                              m_axis_tvalid;
    logic                              m_axis_tready;
    // distance[5:0], odd_count[12:6], even_count[19:13], fill_level[26:20], zeros
    logic [sspc_pkg::OUT_DATA_W-1:0]   m_axis_tdata;
    logic [sspc_pkg::STATUS_W-1:0]     m_axis_tuser;   // status[1:0]

    searchable_stack_parity_count #(
        .CAPACITY   (DEPTH),
        .DATA_WIDTH (sspc_pkg::DATA_WIDTH_DEF)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Shadow copy of the stack. It is updated when an item is accepted, so the
    // stimulus can read the current fill level and contents once send_item returns.
    logic [sspc_pkg::VALUE_W-1:0] shadow_store [DEPTH];
    int                 shadow_fill = 0;
    int                 shadow_odd  = 0;
    int                 shadow_even = 0;

    t_result  pending_results[$];   // expected results, oldest first
    t_request request_notes[$];     // requests offered, waiting to be accepted
    t_request directed_rows[$];

    int fail_count  = 0;
    int sent_count  = 0;            // accepted items that the block does not ignore
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int stall_cycles = 0;
    bit hold_off_pending = 1'b0;

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Applies one request to the shadow stack and returns the result it gives.
    // The data width equals the input width, so the word is stored as it comes.
    function automatic t_result stack_predict(input logic [sspc_pkg::OP_W-1:0] op,
                                              input logic [sspc_pkg::VALUE_W-1:0] word);
        t_result r;
        bit      found;
        r.status   = sspc_pkg::ST_OK;
        r.distance = '0;
        found      = 1'b0;
        case (op)
            sspc_pkg::OP_PUSH: begin
                if (shadow_fill >= DEPTH) begin
                    r.status = sspc_pkg::ST_FULL;
                end else begin
                    shadow_store[shadow_fill] = word;
                    shadow_fill++;
                    if (word[0]) shadow_odd++;
                    else shadow_even++;
                end
            end
            sspc_pkg::OP_POP: begin
                if (shadow_fill == 0) begin
                    r.status = sspc_pkg::ST_EMPTY;
                end else begin
                    shadow_fill--;
                    if (shadow_store[shadow_fill][0]) shadow_odd--;
                    else shadow_even--;
                end
            end
            sspc_pkg::OP_SEARCH: begin
                // Walk down from the top; the first equal word wins.
                for (int i = 0; i < shadow_fill && !found; i++) begin
                    if (shadow_store[shadow_fill - 1 - i] == word) begin
                        found      = 1'b1;
                        r.distance = sspc_pkg::DIST_W'(i);
                    end
                end
                if (!found) r.status = sspc_pkg::ST_NOT_FOUND;
            end
            default: ;
        endcase
        r.odd_count  = sspc_pkg::COUNT_W'(shadow_odd);
        r.even_count = sspc_pkg::COUNT_W'(shadow_even);
        r.fill_level = sspc_pkg::COUNT_W'(shadow_fill);
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] seen);
        if (seen !== want) begin
            $error("%s: expected %0d, got %0d", name, want, seen);
            fail_count++;
        end
    endfunction

    function automatic void add_row(input logic [sspc_pkg::OP_W-1:0] op,
                                    input logic [sspc_pkg::VALUE_W-1:0] value,
                                    input bit has_fixed, input sspc_pkg::t_status status,
                                    input int distance, input int odd_n, input int even_n,
                                    input int fill_n);
        t_request row;
        row.op                = op;
        row.value             = value;
        row.has_fixed         = has_fixed;
        row.fixed.status      = status;
        row.fixed.distance    = sspc_pkg::DIST_W'(distance);
        row.fixed.odd_count   = sspc_pkg::COUNT_W'(odd_n);
        row.fixed.even_count  = sspc_pkg::COUNT_W'(even_n);
        row.fixed.fill_level  = sspc_pkg::COUNT_W'(fill_n);
        directed_rows.push_back(row);
    endfunction

    function automatic t_request plain(input logic [sspc_pkg::OP_W-1:0] op,
                                       input logic [sspc_pkg::VALUE_W-1:0] value);
        t_request req;
        req.op        = op;
        req.value     = value;
        req.has_fixed = 1'b0;
        req.fixed     = '{sspc_pkg::ST_OK, '0, '0, '0, '0};
        return req;
    endfunction

    // Mostly full-range words; some extremes and a small pool of values near
    // zero, so that duplicates appear on the stack and searches hit them.
    function automatic logic [sspc_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return '1;
                    default: return '0;
                endcase
            end
            1, 2, 3: return 32'($urandom_range(7)) - 32'd3;
            default: return $urandom();
        endcase
    endfunction

    // Search keys are mostly words that sit on the stack right now.
    function automatic logic [sspc_pkg::VALUE_W-1:0] pick_key();
        if (shadow_fill > 0 && $urandom_range(9) < 7)
            return shadow_store[$urandom_range(shadow_fill - 1)];
        return pick_value();
    endfunction

    function automatic logic [sspc_pkg::OP_W-1:0] pick_op(input int push_w, input int pop_w,
                                                          input int search_w);
        int r;
        r = $urandom_range(99);
        if (r < push_w) return sspc_pkg::OP_PUSH;
        if (r < push_w + pop_w) return sspc_pkg::OP_POP;
        if (r < push_w + pop_w + search_w) return sspc_pkg::OP_SEARCH;
        return OP_NOP;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    // tvalid stays high between back-to-back items and is lowered only for a gap.
    task automatic send_item(input t_request req);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        request_notes.push_back(req);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= req.value;
        s_axis_tuser  <= req.op;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        if (req.op != OP_NOP) sent_count++;
    endtask

    // Sender pause: no new item until every expected result has come back.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending_results.size() != 0);
    endtask

    // Result checker and predictor, both on the rising edge. A result taken in
    // the same cycle as a new item belongs to an older item, so it is checked first.
    always @(posedge i_clk) begin : monitor
        t_request req;
        t_result  want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_results.size() == 0) begin
                    $error("result with no item waiting for it: tuser %0d, tdata %h",
                           m_axis_tuser, m_axis_tdata);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("status", want.status, m_axis_tuser);
                    check_field("distance", want.distance,
                                m_axis_tdata[sspc_pkg::DIST_W-1:0]);
                    check_field("odd_count", want.odd_count,
                                m_axis_tdata[ODD_LSB +: sspc_pkg::COUNT_W]);
                    check_field("even_count", want.even_count,
                                m_axis_tdata[EVEN_LSB +: sspc_pkg::COUNT_W]);
                    check_field("fill_level", want.fill_level,
                                m_axis_tdata[FILL_LSB +: sspc_pkg::COUNT_W]);
                    check_field("padding", '0,
                                m_axis_tdata[sspc_pkg::OUT_DATA_W-1:PAD_LSB]);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                req  = request_notes.pop_front();
                want = stack_predict(s_axis_tuser, s_axis_tdata);
                if (req.has_fixed) want = req.fixed;
                pending_results.push_back(want);
            end
        end
    end

    // Watchdog: ends the run if neither side moves an item for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles = stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("tb_searchable_stack_parity_count NOT OK");
                $finish;
            end
        end
    end

    // Receiver: random back-pressure, plus one long hold-off on request that
    // lets the block fill its result register and stall its input.
    initial begin : receiver
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_off_pending) begin
                hold_off_pending = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
            end
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial begin : stimulus
        int start_count;
        int mode;
        int run_len;
        logic [sspc_pkg::OP_W-1:0] op;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        tx_idle_pct   = 37;
        rx_idle_pct   = 62;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Fixed rows: empty stack, extreme words and their parity,
        // distances read off the stack contents. The rest goes through the predictor.
        add_row(sspc_pkg::OP_POP,    32'h0000_0000, 1, sspc_pkg::ST_EMPTY,     0, 0, 0, 0);
        add_row(sspc_pkg::OP_SEARCH, 32'h0000_0000, 1, sspc_pkg::ST_NOT_FOUND, 0, 0, 0, 0);
        add_row(OP_NOP,              32'hFFFF_FFFF, 1, sspc_pkg::ST_OK,        0, 0, 0, 0);
        add_row(sspc_pkg::OP_PUSH,   32'h7FFF_FFFF, 1, sspc_pkg::ST_OK,        0, 1, 0, 1);
        add_row(sspc_pkg::OP_PUSH,   32'h8000_0000, 1, sspc_pkg::ST_OK,        0, 1, 1, 2);
        add_row(sspc_pkg::OP_PUSH,   32'hFFFF_FFFF, 1, sspc_pkg::ST_OK,        0, 2, 1, 3);
        add_row(sspc_pkg::OP_PUSH,   32'h0000_0000, 1, sspc_pkg::ST_OK,        0, 2, 2, 4);
        add_row(sspc_pkg::OP_SEARCH, 32'h7FFF_FFFF, 1, sspc_pkg::ST_OK,        3, 2, 2, 4);
        add_row(sspc_pkg::OP_SEARCH, 32'h8000_0000, 1, sspc_pkg::ST_OK,        2, 2, 2, 4);
        add_row(sspc_pkg::OP_SEARCH, 32'hFFFF_FFFF, 1, sspc_pkg::ST_OK,        1, 2, 2, 4);
        add_row(sspc_pkg::OP_SEARCH, 32'h0000_0000, 1, sspc_pkg::ST_OK,        0, 2, 2, 4);
        // A key one bit away from a stored word must miss.
        add_row(sspc_pkg::OP_SEARCH, 32'h7FFF_FFFE, 1, sspc_pkg::ST_NOT_FOUND, 0, 2, 2, 4);
        add_row(sspc_pkg::OP_SEARCH, 32'h0000_0001, 0, sspc_pkg::ST_OK,        0, 0, 0, 0);
        // A duplicate on top: the search must report the nearer copy.
        add_row(sspc_pkg::OP_PUSH,   32'hFFFF_FFFF, 0, sspc_pkg::ST_OK,        0, 0, 0, 0);
        add_row(sspc_pkg::OP_SEARCH, 32'hFFFF_FFFF, 0, sspc_pkg::ST_OK,        0, 0, 0, 0);
        add_row(OP_NOP,              32'h0000_0000, 0, sspc_pkg::ST_OK,        0, 0, 0, 0);
        repeat (5) add_row(sspc_pkg::OP_POP, 32'h0000_0000, 0, sspc_pkg::ST_OK, 0, 0, 0, 0);
        add_row(sspc_pkg::OP_POP,    32'h0000_0000, 1, sspc_pkg::ST_EMPTY,     0, 0, 0, 0);
        foreach (directed_rows[i]) send_item(directed_rows[i]);
        drain();

        // Random part in three phases of idling. Each phase starts with a full
        // sweep (fill to capacity, pushes when full, deep search, pop past
        // empty), then runs episodes that lean toward growth, shrinkage or balance.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct = 37;
                    rx_idle_pct = 62;
                end
                1: begin
                    tx_idle_pct = 62;
                    rx_idle_pct = 37;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                    // Long receiver stall while the sender keeps offering items.
                    hold_off_pending = 1'b1;
                end
            endcase
            start_count = sent_count;

            while (shadow_fill < DEPTH) send_item(plain(sspc_pkg::OP_PUSH, pick_value()));
            repeat (2) send_item(plain(sspc_pkg::OP_PUSH, pick_value()));
            send_item(plain(sspc_pkg::OP_SEARCH, shadow_store[0]));
            send_item(plain(sspc_pkg::OP_SEARCH, pick_value()));
            while (shadow_fill > 0) send_item(plain(sspc_pkg::OP_POP, pick_value()));
            send_item(plain(sspc_pkg::OP_POP, pick_value()));

            while (sent_count - start_count < PHASE_ITEMS) begin
                mode    = $urandom_range(2);
                run_len = $urandom_range(10, 60);
                repeat (run_len) begin
                    case (mode)
                        0: op = pick_op(65, 15, 17);
                        1: op = pick_op(15, 65, 17);
                        default: op = pick_op(35, 30, 32);
                    endcase
                    send_item(plain(op, (op == sspc_pkg::OP_SEARCH) ? pick_key() : pick_value()));
                end
            end
            drain();
        end

        // Any result beyond the expected ones would show up within the tail.
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("tb_searchable_stack_parity_count OK");
        end else begin
            $display("tb_searchable_stack_parity_count NOT OK");
        end
        $finish;
    end

endmodule
